// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked only out of reset
`define IOSL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// checked at every edge, reset included
`define IOSL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IOSL_ASSERT(lbl, clk, rstn, prop, msg)
`define IOSL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/iosl_pkg.sv =====
package iosl_pkg;

  localparam int NODES  = 1024;
  localparam int LINK_W = $clog2(NODES + 1);
  localparam int ADDR_W = $clog2(NODES);
  localparam int IDX_W  = 10;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 11;

  localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NODES);

  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [STAT_W-1:0] status_t;
  typedef logic [LINK_W-1:0] link_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam mode_t MODE_INSERT = 2'd0;
  localparam mode_t MODE_REMOVE = 2'd1;
  localparam mode_t MODE_QUERY  = 2'd2;

  localparam status_t ST_OK         = 2'd0;
  localparam status_t ST_NOT_MEMBER = 2'd1;
  localparam status_t ST_DUPLICATE  = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic eval;
    logic nbr;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;
  } sts_t;

  function automatic link_t idx_to_link(input logic [IDX_W-1:0] ix);
    return LINK_W'(ix);
  endfunction

  function automatic logic idx_in_range(input logic [IDX_W-1:0] ix);
    return 32'(ix) < 32'(NODES);
  endfunction

endpackage

// ===== sv/iosl_ctrl.sv =====
module iosl_ctrl
  import iosl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_NBR   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_NBR;
      S_NBR:   state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign cmd.clear_wr = (state_r == S_CLEAR);
  assign cmd.accept   = (state_r == S_IDLE) && start;
  assign cmd.eval     = (state_r == S_EVAL);
  assign cmd.nbr      = (state_r == S_NBR);

endmodule

// ===== sv/iosl_dp.sv =====
`include "assert_macros.svh"

module iosl_dp
  import iosl_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [IDX_W-1:0]  in_elem_index,
  output logic             out_strobe,
  output logic             out_is_member,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_member_count
);

  // link memories
  link_t next_mem [NODES];
  link_t prev_mem [NODES];

  link_t rd_next_r, rd_prev_r;
  addr_t rd_addr;

  addr_t clr_addr_r;

  mode_t            mode_r;
  logic [IDX_W-1:0] idx_r;
  logic             idx_ok_r;

  link_t            head_r, head_nxt;
  link_t            tail_r, tail_nxt;
  link_t            count_r, count_nxt;

  // neighbor writes, issued the cycle after the self-entry writes
  logic  nbr_next_we_r, nbr_next_we_nxt;
  addr_t nbr_next_addr_r, nbr_next_addr_nxt;
  link_t nbr_next_data_r, nbr_next_data_nxt;
  logic  nbr_prev_we_r, nbr_prev_we_nxt;
  addr_t nbr_prev_addr_r, nbr_prev_addr_nxt;
  link_t nbr_prev_data_r, nbr_prev_data_nxt;

  logic    self_we;
  link_t   self_prev;
  link_t   ix_link;
  logic    member;
  logic    res_member;
  status_t res_status;

  logic  nw_en, pw_en;
  addr_t nw_addr, pw_addr;
  link_t nw_data, pw_data;

  logic             out_strobe_r;
  logic             out_is_member_r;
  status_t          out_status_r;
  logic [CNT_W-1:0] out_member_count_r;

  assign rd_addr = addr_t'(in_elem_index);
  assign sts.clear_last = (clr_addr_r == ADDR_W'(NODES - 1));

  always_comb begin
    ix_link = idx_to_link(idx_r);
    // a lone member has no links but sits at the head
    member  = idx_ok_r && !((rd_next_r == NONE_LINK) && (rd_prev_r == NONE_LINK) &&
                            (head_r != ix_link));
    self_we    = 1'b0;
    self_prev  = NONE_LINK;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    count_nxt  = count_r;
    res_member = member;
    res_status = ST_OK;
    nbr_next_we_nxt   = 1'b0;
    nbr_next_addr_nxt = rd_next_r[ADDR_W-1:0];
    nbr_next_data_nxt = NONE_LINK;
    nbr_prev_we_nxt   = 1'b0;
    nbr_prev_addr_nxt = rd_next_r[ADDR_W-1:0];
    nbr_prev_data_nxt = NONE_LINK;
    unique case (mode_r)
      MODE_INSERT: begin
        if (member) begin
          res_status = ST_DUPLICATE;
        end else if (idx_ok_r) begin
          self_we = 1'b1;
          if (head_r == NONE_LINK) begin
            head_nxt = ix_link;
          end else begin
            self_prev = tail_r;
            if (tail_r < NONE_LINK) begin
              nbr_next_we_nxt   = 1'b1;
              nbr_next_addr_nxt = tail_r[ADDR_W-1:0];
              nbr_next_data_nxt = ix_link;
            end
          end
          tail_nxt   = ix_link;
          count_nxt  = LINK_W'(count_r + 1'b1);
          res_member = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (member) begin
          self_we = 1'b1;
          if (ix_link == tail_r) begin
            tail_nxt = rd_prev_r;
          end else if (rd_next_r < NONE_LINK) begin
            nbr_prev_we_nxt   = 1'b1;
            nbr_prev_addr_nxt = rd_next_r[ADDR_W-1:0];
            nbr_prev_data_nxt = rd_prev_r;
          end
          if (ix_link == head_r) begin
            head_nxt = rd_next_r;
          end else if (rd_prev_r < NONE_LINK) begin
            nbr_next_we_nxt   = 1'b1;
            nbr_next_addr_nxt = rd_prev_r[ADDR_W-1:0];
            nbr_next_data_nxt = rd_next_r;
          end
          if (count_r != '0) count_nxt = LINK_W'(count_r - 1'b1);
          res_member = 1'b0;
        end else begin
          res_status = ST_NOT_MEMBER;
        end
      end
      default: ;  // query, and the spare code acts as one
    endcase
  end

  // write port select: clearing sweep, self entry, then neighbors
  always_comb begin
    nw_en   = 1'b0;
    nw_addr = clr_addr_r;
    nw_data = NONE_LINK;
    pw_en   = 1'b0;
    pw_addr = clr_addr_r;
    pw_data = NONE_LINK;
    if (cmd.clear_wr) begin
      nw_en = 1'b1;
      pw_en = 1'b1;
    end else if (cmd.eval) begin
      nw_en   = self_we;
      nw_addr = ix_link[ADDR_W-1:0];
      pw_en   = self_we;
      pw_addr = ix_link[ADDR_W-1:0];
      pw_data = self_prev;
    end else if (cmd.nbr) begin
      nw_en   = nbr_next_we_r;
      nw_addr = nbr_next_addr_r;
      nw_data = nbr_next_data_r;
      pw_en   = nbr_prev_we_r;
      pw_addr = nbr_prev_addr_r;
      pw_data = nbr_prev_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (cmd.accept) rd_next_r <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pw_en) prev_mem[pw_addr] <= pw_data;
    if (cmd.accept) rd_prev_r <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r    <= '0;
      head_r        <= NONE_LINK;
      tail_r        <= NONE_LINK;
      count_r       <= '0;
      nbr_next_we_r <= 1'b0;
      nbr_prev_we_r <= 1'b0;
      out_strobe_r  <= 1'b0;
    end else begin
      if (cmd.clear_wr) clr_addr_r <= ADDR_W'(clr_addr_r + 1'b1);
      out_strobe_r <= cmd.eval;
      if (cmd.eval) begin
        head_r        <= head_nxt;
        tail_r        <= tail_nxt;
        count_r       <= count_nxt;
        nbr_next_we_r <= nbr_next_we_nxt;
        nbr_prev_we_r <= nbr_prev_we_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_mode;
      idx_r    <= in_elem_index;
      idx_ok_r <= idx_in_range(in_elem_index);
    end
    if (cmd.eval) begin
      nbr_next_addr_r    <= nbr_next_addr_nxt;
      nbr_next_data_r    <= nbr_next_data_nxt;
      nbr_prev_addr_r    <= nbr_prev_addr_nxt;
      nbr_prev_data_r    <= nbr_prev_data_nxt;
      out_is_member_r    <= res_member;
      out_status_r       <= res_status;
      out_member_count_r <= CNT_W'(count_nxt);
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_is_member    = out_is_member_r;
  assign out_status       = out_status_r;
  assign out_member_count = out_member_count_r;

  `IOSL_ASSERT(a_empty_heads, clk, rst_n, (head_r == NONE_LINK) == (count_r == '0), "head pointer disagrees with member count")
  `IOSL_ASSERT(a_head_tail, clk, rst_n, (head_r == NONE_LINK) == (tail_r == NONE_LINK), "head and tail pointers disagree on empty list")
  `IOSL_ASSERT(a_count_max, clk, rst_n, count_r <= LINK_W'(NODES), "member count above capacity")

endmodule

// ===== sv/indexed_ordered_set_list_unit.sv =====
// channel  ports                                          handshake
// -------  ---------------------------------------------  ------------------------
// input    in_mode, in_elem_index                         start high, busy low
// result   out_is_member, out_status, out_member_count    out_strobe, one cycle
//
// Each word is accepted with the link memory read, evaluated with the
// self-entry write, then finished with the neighbor-entry writes while the result is shown.
// The single write port of each link memory keeps these writes in separate steps.
// After reset the link memories are swept to empty, one entry a cycle, over
// all NODES (1024) entries with busy held high.
// The receiver cannot stall: out_strobe is high for exactly one cycle.
`include "assert_macros.svh"

module indexed_ordered_set_list_unit
  import iosl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [IDX_W-1:0]  in_elem_index,
  output logic              out_strobe,
  output logic              out_is_member,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_member_count
);

  cmd_t cmd;
  sts_t sts;

  iosl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  iosl_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_mode          (in_mode),
    .in_elem_index    (in_elem_index),
    .out_strobe       (out_strobe),
    .out_is_member    (out_is_member),
    .out_status       (out_status),
    .out_member_count (out_member_count)
  );

  `IOSL_ASSERT(a_result_follows, clk, rst_n, (start && !busy) |=> ##1 out_strobe, "no result two cycles after accept")
  `IOSL_ASSERT(a_idle_after, clk, rst_n, out_strobe |=> !busy, "not idle after result word")
  `IOSL_ASSERT(a_status_member, clk, rst_n, (out_strobe && (out_status == ST_DUPLICATE)) |-> out_is_member, "duplicate insert reported as non-member")

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import iosl_pkg::*;

  localparam mode_t MODE_UNUSED  = 2'd3;
  localparam int    STALL_LIMIT  = 4000;
  localparam int    DRAIN_CYCLES = 8;

  typedef struct packed {
    logic               member;
    status_t            status;
    logic [CNT_W-1:0]   count;
  } list_answer_t;

  class list_shadow;
    link_t            next_of [NODES];
    link_t            prev_of [NODES];
    link_t            head_at;
    link_t            tail_at;
    logic [CNT_W-1:0] size_now;
    int               peak;
    int               errors;
    int               checked;
    list_answer_t     expected_answers[$];

    function new();
      for (int i = 0; i < NODES; i++) begin
        next_of[i] = NONE_LINK;
        prev_of[i] = NONE_LINK;
      end
      head_at  = NONE_LINK;
      tail_at  = NONE_LINK;
      size_now = '0;
      peak     = 0;
      errors   = 0;
      checked  = 0;
    endfunction

    // a lone member has no links, so head decides
    function bit holds(logic [IDX_W-1:0] ix);
      if (int'(ix) >= NODES) return 1'b0;
      return !(next_of[ix] == NONE_LINK && prev_of[ix] == NONE_LINK &&
               head_at != LINK_W'(ix));
    endfunction

    function void append(logic [IDX_W-1:0] ix);
      if (head_at == NONE_LINK) begin
        head_at     = LINK_W'(ix);
        prev_of[ix] = NONE_LINK;
      end else begin
        prev_of[ix] = tail_at;
        if (int'(tail_at) < NODES) next_of[tail_at[ADDR_W-1:0]] = LINK_W'(ix);
      end
      next_of[ix] = NONE_LINK;
      tail_at     = LINK_W'(ix);
      size_now    = size_now + 1'b1;
    endfunction

    function void unlink(logic [IDX_W-1:0] ix);
      link_t nx;
      link_t pv;
      link_t self;
      nx   = next_of[ix];
      pv   = prev_of[ix];
      self = LINK_W'(ix);
      if (self == tail_at) tail_at = pv;
      else if (int'(nx) < NODES) prev_of[nx[ADDR_W-1:0]] = pv;
      if (self == head_at) head_at = nx;
      else if (int'(pv) < NODES) next_of[pv[ADDR_W-1:0]] = nx;
      next_of[ix] = NONE_LINK;
      prev_of[ix] = NONE_LINK;
      if (size_now != 0) size_now = size_now - 1'b1;
    endfunction

    function void note_word(mode_t m, logic [IDX_W-1:0] ix);
      list_answer_t a;
      bit           hit;
      hit      = holds(ix);
      a.status = ST_OK;
      case (m)
        MODE_INSERT: begin
          if (hit) a.status = ST_DUPLICATE;
          else if (int'(ix) < NODES) begin
            append(ix);
            hit = 1'b1;
          end
        end
        MODE_REMOVE: begin
          if (hit) begin
            unlink(ix);
            hit = 1'b0;
          end else begin
            a.status = ST_NOT_MEMBER;
          end
        end
        default: ;  // query, the unused code included
      endcase
      a.member = hit;
      a.count  = size_now;
      if (int'(size_now) > peak) peak = int'(size_now);
      expected_answers.push_back(a);
    endfunction

    function void check_word(logic mem, status_t st, logic [CNT_W-1:0] cnt);
      list_answer_t want;
      if (expected_answers.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: is_member %0b status %0d count %0d",
                 $time, mem, st, cnt);
        return;
      end
      want = expected_answers.pop_front();
      checked++;
      if (mem !== want.member) begin
        errors++;
        $display("%0t: is_member expected %0b actual %0b", $time, want.member, mem);
      end
      if (st !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, st);
      end
      if (cnt !== want.count) begin
        errors++;
        $display("%0t: member_count expected %0d actual %0d", $time, want.count, cnt);
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst_n         = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  mode_t             in_mode       = MODE_QUERY;
  logic [IDX_W-1:0]  in_elem_index = '0;
  logic              out_strobe;
  logic              out_is_member;
  status_t           out_status;
  logic [CNT_W-1:0]  out_member_count;

  list_shadow board;
  int         quiet_cycles = 0;
  int         n_insert     = 0;
  int         n_remove     = 0;
  int         n_query      = 0;

  indexed_ordered_set_list_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_elem_index    (in_elem_index),
    .out_strobe       (out_strobe),
    .out_is_member    (out_is_member),
    .out_status       (out_status),
    .out_member_count (out_member_count)
  );

  always #10 clk = ~clk;

  // results are checked before the word accepted at the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe) board.check_word(out_is_member, out_status, out_member_count);
      if (start && !busy) begin
        board.note_word(in_mode, in_elem_index);
        case (in_mode)
          MODE_INSERT: n_insert++;
          MODE_REMOVE: n_remove++;
          default:     n_query++;
        endcase
      end
      if (out_strobe || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: timeout, no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_word(mode_t m, logic [IDX_W-1:0] ix);
    @(negedge clk);
    start         <= 1'b1;
    in_mode       <= m;
    in_elem_index <= ix;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_gap(int n);
    repeat (n) begin
      @(negedge clk);
      start         <= 1'b0;
      in_mode       <= mode_t'($urandom);
      in_elem_index <= IDX_W'($urandom);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (board.expected_answers.size() != 0) @(posedge clk);
  endtask

  // low indices collide often, so removes and duplicates hit members
  function automatic logic [IDX_W-1:0] pick_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return IDX_W'($urandom_range(0, 47));
    if (r < 62) return IDX_W'($urandom_range(NODES - 24, NODES - 1));
    return IDX_W'($urandom);
  endfunction

  task automatic random_burst(int n, int ins_pct, int rem_pct, bit with_gaps);
    int    r;
    mode_t m;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < ins_pct) m = MODE_INSERT;
      else if (r < ins_pct + rem_pct) m = MODE_REMOVE;
      else if (r < 97) m = MODE_QUERY;
      else m = MODE_UNUSED;
      send_word(m, pick_index());
      if (with_gaps && $urandom_range(0, 99) < 11) pause_gap($urandom_range(1, 5));
    end
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(MODE_QUERY,  IDX_W'(0));      // empty list
    send_word(MODE_REMOVE, IDX_W'(5));      // remove from empty list
    send_word(MODE_INSERT, IDX_W'(0));      // lone member
    send_word(MODE_QUERY,  IDX_W'(0));
    send_word(MODE_UNUSED, IDX_W'(0));
    send_word(MODE_INSERT, IDX_W'(0));      // duplicate
    send_word(MODE_REMOVE, IDX_W'(0));
    send_word(MODE_QUERY,  IDX_W'(0));
    send_word(MODE_INSERT, IDX_W'(NODES - 1));
    send_word(MODE_INSERT, IDX_W'(0));
    send_word(MODE_INSERT, IDX_W'(512));
    send_word(MODE_REMOVE, IDX_W'(512));    // tail
    send_word(MODE_INSERT, IDX_W'(341));
    send_word(MODE_INSERT, IDX_W'(682));
    send_word(MODE_REMOVE, IDX_W'(0));      // middle
    send_word(MODE_REMOVE, IDX_W'(NODES - 1)); // head
    send_word(MODE_QUERY,  IDX_W'(NODES - 1));
    send_word(MODE_REMOVE, IDX_W'(NODES - 1)); // non-member
    send_word(MODE_UNUSED, IDX_W'(682));
    send_word(MODE_REMOVE, IDX_W'(682));
    send_word(MODE_REMOVE, IDX_W'(341));    // list empty again
    send_word(MODE_QUERY,  IDX_W'(341));

    random_burst(200, 50, 25, 1'b1);
    wait_drained();
    random_burst(130, 40, 40, 1'b0);
    random_burst(200, 30, 50, 1'b1);
    wait_drained();

    send_word(MODE_INSERT, pick_index());
    send_word(MODE_QUERY,  pick_index());
    random_burst(60, 10, 70, 1'b1);
    random_burst(30, 45, 35, 1'b1);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run moved %0d words: %0d inserts, %0d removes, %0d queries; %0d results compared.",
             n_insert + n_remove + n_query, n_insert, n_remove, n_query, board.checked);
    $display("Membership peaked at %0d of %0d indices.", board.peak, NODES);
    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
